// File: design/lsc_pkg.sv
// Shared constants, types and the fixed segment range table of the LED color scaler.
package lsc_pkg;

   localparam int LED_COUNT_DEF     = 283;
   localparam int REDLINE_END_DEF   = 77;
   localparam int TABLE_ENTRIES_DEF = 28;

   localparam int STORED_ENTRIES = 28;
   localparam int RPM_ENTRY      = 15;
   localparam int SEL_W          = $clog2(STORED_ENTRIES);

   localparam int IDX_W      = 9;
   localparam int CH_W       = 8;
   localparam int COLOR_W    = 3 * CH_W;
   localparam int BRIGHT_W   = 8;
   localparam int REDLINE_W  = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_FIELD_W = IDX_W + COLOR_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [CSR_IDX_W-1:0] REG_MAIN_COLOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BACK_COLOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BRIGHTNESS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REDLINE    = 2'd3;

   localparam logic [COLOR_W-1:0]  MAIN_COLOR_RST    = '0;
   localparam logic [COLOR_W-1:0]  BACK_COLOR_RST    = '0;
   localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RST    = 8'd30;
   localparam logic [REDLINE_W-1:0] REDLINE_RST      = '0;
   localparam logic [COLOR_W-1:0]  MAIN_COLOR_DEFAULT = {8'd180, 8'd240, 8'd6};

   // floor(x / 3) = (x * 171) >> 9 for any 8-bit x
   localparam logic [CH_W-1:0] DIV3_MUL   = 8'd171;
   localparam int              DIV3_SHIFT = 9;

   // floor(p / 100) = (p * 167773) >> 24 for any 16-bit p
   localparam int               PROD_W       = CH_W + BRIGHT_W;
   localparam int               RECIP_W      = 18;
   localparam logic [RECIP_W-1:0] RECIP_100  = 18'd167773;
   localparam int               RECIP_SHIFT  = 24;
   localparam int               QUOT_W       = 10;

   typedef logic [1:0] src_type;
   localparam src_type SRC_FIXED = 2'd0;
   localparam src_type SRC_MAIN  = 2'd1;
   localparam src_type SRC_DIM   = 2'd2;
   localparam src_type SRC_BACK  = 2'd3;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rgb_type;

   localparam logic [IDX_W-1:0] SEG_END [STORED_ENTRIES] = '{
      9'd1,   9'd15,  9'd16,  9'd17,  9'd18,  9'd19,  9'd20,
      9'd21,  9'd22,  9'd23,  9'd24,  9'd25,  9'd26,  9'd27,
      9'd28,  9'd77,  9'd77,  9'd95,  9'd137, 9'd138, 9'd168,
      9'd175, 9'd206, 9'd221, 9'd227, 9'd269, 9'd270, 9'd282
   };

   localparam src_type SEG_SOURCE [STORED_ENTRIES] = '{
      SRC_DIM,   SRC_MAIN,  SRC_MAIN,  SRC_FIXED, SRC_FIXED, SRC_FIXED, SRC_FIXED,
      SRC_FIXED, SRC_FIXED, SRC_FIXED, SRC_FIXED, SRC_FIXED, SRC_FIXED, SRC_FIXED,
      SRC_FIXED, SRC_MAIN,  SRC_FIXED, SRC_DIM,   SRC_MAIN,  SRC_MAIN,  SRC_MAIN,
      SRC_MAIN,  SRC_MAIN,  SRC_MAIN,  SRC_FIXED, SRC_MAIN,  SRC_DIM,   SRC_BACK
   };

   localparam logic [COLOR_W-1:0] SEG_COLOR [STORED_ENTRIES] = '{
      24'h141402, 24'h3C0802, 24'h3C5002, 24'h02F002, 24'h02F002, 24'hF00202,
      24'hF00202, 24'hF00202, 24'h02F002, 24'h02F002, 24'h020278, 24'h3C5002,
      24'h3C5002, 24'h02F002, 24'h025002, 24'h3C0802, 24'h780802, 24'h141402,
      24'h3C5002, 24'h3C5002, 24'h06083C, 24'h3C5002, 24'h3C5002, 24'h020250,
      24'h500202, 24'h3C0802, 24'h141402, 24'h3C5002
   };

endpackage

// File: design/lsc_channel_scale.sv
// One color channel: multiply by brightness, divide by 100, saturate at 255.
module lsc_channel_scale (
   input  logic                            clock,
   input  logic                            enable,
   input  logic [lsc_pkg::CH_W-1:0]        channel,
   input  logic [lsc_pkg::BRIGHT_W-1:0]    brightness,
   output logic [lsc_pkg::CH_W-1:0]        scaled
);

   localparam int FULL_W = lsc_pkg::PROD_W + lsc_pkg::RECIP_W;

   logic [lsc_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [FULL_W-1:0]          quot_ff, quot_in;
   logic [lsc_pkg::CH_W-1:0]   scaled_ff, scaled_in;
   logic [lsc_pkg::QUOT_W-1:0] quot;

   assign prod_in = lsc_pkg::PROD_W'(channel) * lsc_pkg::PROD_W'(brightness);
   assign quot_in = FULL_W'(prod_ff) * FULL_W'(lsc_pkg::RECIP_100);
   assign quot    = quot_ff[lsc_pkg::RECIP_SHIFT +: lsc_pkg::QUOT_W];

   always_comb begin
      if (quot > lsc_pkg::QUOT_W'(255)) begin
         scaled_in = '1;
      end else begin
         scaled_in = quot[lsc_pkg::CH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff   <= prod_in;
         quot_ff   <= quot_in;
         scaled_ff <= scaled_in;
      end
   end

   assign scaled = scaled_ff;

endmodule

// File: design/led_segment_color_scaler.sv
// Top level: LED segment color lookup and brightness scaling pipeline.
// Throughput: one transaction per cycle; six register stages (range compare,
// priority select, color source, brightness multiply, divide by 100, output)
// all advance together whenever the output register is empty or taken.
// Reset: synchronous, clears all stage valid bits and loads register defaults.
module led_segment_color_scaler #(
   parameter int LED_COUNT     = lsc_pkg::LED_COUNT_DEF,
   parameter int REDLINE_END   = lsc_pkg::REDLINE_END_DEF,
   parameter int TABLE_ENTRIES = lsc_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lsc_pkg::REQ_TDATA_W-1:0]   req_tdata,  // led_index[8:0], zero pad
   input  logic [lsc_pkg::REQ_TUSER_W-1:0]   req_tuser,  // segment_on[0], blank[1]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lsc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // pixel_index[8:0], red[16:9],
                                                         // green[24:17], blue[32:25], zero pad
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lsc_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int IW = lsc_pkg::IDX_W;
   localparam int NE = lsc_pkg::STORED_ENTRIES;
   localparam logic [IW:0]   LedCountW   = (IW+1)'(LED_COUNT);
   localparam logic [IW-1:0] RedlineEndW = IW'(REDLINE_END);

   logic [lsc_pkg::COLOR_W-1:0]   main_color_ff;
   logic [lsc_pkg::COLOR_W-1:0]   back_color_ff;
   logic [lsc_pkg::BRIGHT_W-1:0]  brightness_ff;
   logic [lsc_pkg::REDLINE_W-1:0] redline_ff;

   logic advance;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, vout_ff;
   logic [IW-1:0] idx1_ff, idx2_ff, idx3_ff, idx4_ff, idx5_ff, idxout_ff;
   logic on1_ff, on2_ff;
   logic [NE-1:0] hit1_ff, hit_in;
   logic [lsc_pkg::SEL_W-1:0] sel2_ff, sel_in;
   logic any2_ff;
   lsc_pkg::rgb_type color3_ff, color_in;
   lsc_pkg::rgb_type scaled;

   logic [IW-1:0] req_idx;
   logic          req_on;
   logic [IW-1:0] rpm_end;
   logic [IW-1:0] seg_end [NE];
   lsc_pkg::rgb_type main_rgb, dim_rgb, back_rgb;
   logic [lsc_pkg::COLOR_W-1:0] main_eff;

   assign advance    = !vout_ff || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   assign req_idx = req_tdata[IW-1:0];
   assign req_on  = req_tuser[0] && !req_tuser[1] && ({1'b0, req_idx} < LedCountW);

   always_ff @(posedge clock) begin
      if (reset) begin
         main_color_ff <= lsc_pkg::MAIN_COLOR_RST;
         back_color_ff <= lsc_pkg::BACK_COLOR_RST;
         brightness_ff <= lsc_pkg::BRIGHTNESS_RST;
         redline_ff    <= lsc_pkg::REDLINE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            lsc_pkg::REG_MAIN_COLOR: main_color_ff <= csr_data;
            lsc_pkg::REG_BACK_COLOR: back_color_ff <= csr_data;
            lsc_pkg::REG_BRIGHTNESS: brightness_ff <= csr_data[lsc_pkg::BRIGHT_W-1:0];
            lsc_pkg::REG_REDLINE:    redline_ff    <= csr_data[lsc_pkg::REDLINE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (IW'(redline_ff) > RedlineEndW) begin
         rpm_end = '0;
      end else begin
         rpm_end = RedlineEndW - IW'(redline_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < NE; i++) begin
         if (i == lsc_pkg::RPM_ENTRY) begin
            seg_end[i] = rpm_end;
         end else begin
            seg_end[i] = lsc_pkg::SEG_END[i];
         end
      end
      hit_in[0] = (TABLE_ENTRIES > 0) && (req_idx < seg_end[0]);
      for (int i = 1; i < NE; i++) begin
         hit_in[i] = (i < TABLE_ENTRIES) && (req_idx >= seg_end[i-1])
                     && (req_idx < seg_end[i]);
      end
   end

   always_comb begin
      sel_in = '0;
      for (int i = 0; i < NE; i++) begin
         if (hit1_ff[i]) begin
            sel_in = lsc_pkg::SEL_W'(i);
         end
      end
   end

   assign main_eff = (main_color_ff == '0) ? lsc_pkg::MAIN_COLOR_DEFAULT : main_color_ff;
   assign main_rgb = main_eff;
   assign back_rgb = back_color_ff;

   function automatic logic [lsc_pkg::CH_W-1:0] div3(input logic [lsc_pkg::CH_W-1:0] x);
      logic [2*lsc_pkg::CH_W-1:0] p;
      p = (2*lsc_pkg::CH_W)'(x) * (2*lsc_pkg::CH_W)'(lsc_pkg::DIV3_MUL);
      return lsc_pkg::CH_W'(p >> lsc_pkg::DIV3_SHIFT);
   endfunction

   assign dim_rgb.red   = div3(main_rgb.red);
   assign dim_rgb.green = div3(main_rgb.green);
   assign dim_rgb.blue  = div3(main_rgb.blue);

   always_comb begin
      if (!on2_ff || !any2_ff) begin
         color_in = '0;
      end else begin
         unique case (lsc_pkg::SEG_SOURCE[sel2_ff])
            lsc_pkg::SRC_FIXED: color_in = lsc_pkg::SEG_COLOR[sel2_ff];
            lsc_pkg::SRC_MAIN:  color_in = main_rgb;
            lsc_pkg::SRC_DIM:   color_in = dim_rgb;
            lsc_pkg::SRC_BACK:  color_in = back_rgb;
            default:            color_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         v5_ff   <= 1'b0;
         vout_ff <= 1'b0;
      end else if (advance) begin
         v1_ff   <= req_tvalid;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         v4_ff   <= v3_ff;
         v5_ff   <= v4_ff;
         vout_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         idx1_ff   <= req_idx;
         on1_ff    <= req_on;
         hit1_ff   <= hit_in;
         idx2_ff   <= idx1_ff;
         on2_ff    <= on1_ff;
         sel2_ff   <= sel_in;
         any2_ff   <= |hit1_ff;
         idx3_ff   <= idx2_ff;
         color3_ff <= color_in;
         idx4_ff   <= idx3_ff;
         idx5_ff   <= idx4_ff;
         idxout_ff <= idx5_ff;
      end
   end

   lsc_channel_scale u_scale_red (
      .clock      (clock),
      .enable     (advance),
      .channel    (color3_ff.red),
      .brightness (brightness_ff),
      .scaled     (scaled.red)
   );

   lsc_channel_scale u_scale_green (
      .clock      (clock),
      .enable     (advance),
      .channel    (color3_ff.green),
      .brightness (brightness_ff),
      .scaled     (scaled.green)
   );

   lsc_channel_scale u_scale_blue (
      .clock      (clock),
      .enable     (advance),
      .channel    (color3_ff.blue),
      .brightness (brightness_ff),
      .scaled     (scaled.blue)
   );

   assign rsp_tvalid = vout_ff;
   assign rsp_tdata  = lsc_pkg::RSP_TDATA_W'({scaled.blue, scaled.green, scaled.red, idxout_ff});

endmodule

// File: design/lsc_checker.sv
// Port-level checker for the LED color scaler, bound to the top level.
module lsc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [lsc_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty output");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[lsc_pkg::RSP_TDATA_W-1:lsc_pkg::RSP_FIELD_W] == '0)
      else $error("result padding not zero");

endmodule

bind led_segment_color_scaler lsc_checker u_lsc_checker (.*);

// File: test/led_segment_color_scaler_tb.sv
// Testbench for the LED segment color scaler: directed and random pixels against a predictor.
`timescale 1ns / 1ps

module led_segment_color_scaler_tb;

   localparam int LED_TOTAL      = 283;
   localparam int REDLINE_LIMIT  = 77;
   localparam int SPAN_COUNT     = 28;
   localparam int RPM_SPAN       = 15;
   localparam int PIPE_DEPTH     = 6;
   localparam int LONG_HOLD      = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRINT_CAP      = 40;
   localparam logic [lsc_pkg::COLOR_W-1:0] DEFAULT_MAIN = {8'd180, 8'd240, 8'd6};

   localparam int unsigned SPAN_END [SPAN_COUNT] = '{
      1,   15,  16,  17,  18,  19,  20,  21,  22,  23,  24,  25,  26,  27,
      28,  77,  77,  95,  137, 138, 168, 175, 206, 221, 227, 269, 270, 282
   };

   localparam lsc_pkg::src_type SPAN_SRC [SPAN_COUNT] = '{
      lsc_pkg::SRC_DIM,   lsc_pkg::SRC_MAIN,  lsc_pkg::SRC_MAIN,  lsc_pkg::SRC_FIXED,
      lsc_pkg::SRC_FIXED, lsc_pkg::SRC_FIXED, lsc_pkg::SRC_FIXED, lsc_pkg::SRC_FIXED,
      lsc_pkg::SRC_FIXED, lsc_pkg::SRC_FIXED, lsc_pkg::SRC_FIXED, lsc_pkg::SRC_FIXED,
      lsc_pkg::SRC_FIXED, lsc_pkg::SRC_FIXED, lsc_pkg::SRC_FIXED, lsc_pkg::SRC_MAIN,
      lsc_pkg::SRC_FIXED, lsc_pkg::SRC_DIM,   lsc_pkg::SRC_MAIN,  lsc_pkg::SRC_MAIN,
      lsc_pkg::SRC_MAIN,  lsc_pkg::SRC_MAIN,  lsc_pkg::SRC_MAIN,  lsc_pkg::SRC_MAIN,
      lsc_pkg::SRC_FIXED, lsc_pkg::SRC_MAIN,  lsc_pkg::SRC_DIM,   lsc_pkg::SRC_BACK
   };

   localparam logic [lsc_pkg::COLOR_W-1:0] SPAN_RGB [SPAN_COUNT] = '{
      24'h141402, 24'h3C0802, 24'h3C5002, 24'h02F002, 24'h02F002, 24'hF00202,
      24'hF00202, 24'hF00202, 24'h02F002, 24'h02F002, 24'h020278, 24'h3C5002,
      24'h3C5002, 24'h02F002, 24'h025002, 24'h3C0802, 24'h780802, 24'h141402,
      24'h3C5002, 24'h3C5002, 24'h06083C, 24'h3C5002, 24'h3C5002, 24'h020250,
      24'h500202, 24'h3C0802, 24'h141402, 24'h3C5002
   };

   typedef struct packed {
      logic [lsc_pkg::IDX_W-1:0] index;
      logic [lsc_pkg::CH_W-1:0]  red;
      logic [lsc_pkg::CH_W-1:0]  green;
      logic [lsc_pkg::CH_W-1:0]  blue;
   } pixel_type;

   typedef struct packed {
      logic [lsc_pkg::IDX_W-1:0]   index;
      logic                        lit;
      logic                        blank;
      logic                        known;
      logic [lsc_pkg::COLOR_W-1:0] rgb;
   } led_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [lsc_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic [lsc_pkg::REQ_TUSER_W-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [lsc_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_valid;
   logic csr_ready;
   logic [lsc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [lsc_pkg::CSR_DATA_W-1:0] csr_data;

   logic [lsc_pkg::COLOR_W-1:0]   main_cfg    = lsc_pkg::MAIN_COLOR_RST;
   logic [lsc_pkg::COLOR_W-1:0]   back_cfg    = lsc_pkg::BACK_COLOR_RST;
   logic [lsc_pkg::BRIGHT_W-1:0]  bright_cfg  = lsc_pkg::BRIGHTNESS_RST;
   logic [lsc_pkg::REDLINE_W-1:0] redline_cfg = lsc_pkg::REDLINE_RST;

   pixel_type pixel_expect[$];
   int     mismatch_count = 0;
   int     quiet_cycles = 0;
   bit     steady = 1'b0;
   int     hold_asked = 0;
   int     hold_served = 0;
   int     hold_left = 0;

   led_row_type led_rows [23] = '{
      '{9'd0,   1'b1, 1'b0, 1'b0, 24'h0},
      '{9'd1,   1'b1, 1'b0, 1'b0, 24'h0},
      '{9'd14,  1'b1, 1'b0, 1'b0, 24'h0},
      '{9'd15,  1'b1, 1'b0, 1'b0, 24'h0},
      '{9'd16,  1'b1, 1'b0, 1'b0, 24'h0},
      '{9'd20,  1'b1, 1'b0, 1'b0, 24'h0},
      '{9'd24,  1'b1, 1'b0, 1'b0, 24'h0},
      '{9'd27,  1'b1, 1'b0, 1'b0, 24'h0},
      '{9'd28,  1'b1, 1'b0, 1'b0, 24'h0},
      '{9'd76,  1'b1, 1'b0, 1'b0, 24'h0},
      '{9'd77,  1'b1, 1'b0, 1'b0, 24'h0},
      '{9'd94,  1'b1, 1'b0, 1'b0, 24'h0},
      '{9'd167, 1'b1, 1'b0, 1'b0, 24'h0},
      '{9'd220, 1'b1, 1'b0, 1'b0, 24'h0},
      '{9'd226, 1'b1, 1'b0, 1'b0, 24'h0},
      '{9'd269, 1'b1, 1'b0, 1'b0, 24'h0},
      '{9'd281, 1'b1, 1'b0, 1'b0, 24'h0},
      '{9'd282, 1'b1, 1'b0, 1'b1, 24'h0},
      '{9'd283, 1'b1, 1'b0, 1'b1, 24'h0},
      '{9'd511, 1'b1, 1'b0, 1'b1, 24'h0},
      '{9'd100, 1'b0, 1'b0, 1'b1, 24'h0},
      '{9'd100, 1'b1, 1'b1, 1'b1, 24'h0},
      '{9'd300, 1'b0, 1'b1, 1'b1, 24'h0}
   };

   led_segment_color_scaler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [lsc_pkg::CH_W-1:0] scale_level(
         input logic [lsc_pkg::CH_W-1:0] level);
      int unsigned product;
      product = (int'(level) * int'(bright_cfg)) / 100;
      return (product > 255) ? 8'd255 : product[lsc_pkg::CH_W-1:0];
   endfunction

   function automatic pixel_type shade_pixel(input logic [lsc_pkg::IDX_W-1:0] index,
                                             input logic lit, input logic blank);
      pixel_type                   px;
      logic [lsc_pkg::COLOR_W-1:0] base;
      logic [lsc_pkg::COLOR_W-1:0] pick;
      int unsigned                 start;
      int unsigned                 stop;
      base  = (main_cfg != '0) ? main_cfg : DEFAULT_MAIN;
      pick  = '0;
      start = 0;
      for (int i = 0; i < SPAN_COUNT; i++) begin
         if (i == RPM_SPAN)
            stop = (redline_cfg > REDLINE_LIMIT) ? 0 : REDLINE_LIMIT - redline_cfg;
         else
            stop = SPAN_END[i];
         if (index >= start && index < stop) begin
            case (SPAN_SRC[i])
               lsc_pkg::SRC_MAIN: pick = base;
               lsc_pkg::SRC_DIM:  pick = {base[23:16] / 8'd3, base[15:8] / 8'd3,
                                          base[7:0] / 8'd3};
               lsc_pkg::SRC_BACK: pick = back_cfg;
               default:           pick = SPAN_RGB[i];
            endcase
         end
         start = stop;
      end
      px.index = index;
      if (lit && !blank && index < LED_TOTAL) begin
         px.red   = scale_level(pick[23:16]);
         px.green = scale_level(pick[15:8]);
         px.blue  = scale_level(pick[7:0]);
      end else begin
         px.red   = '0;
         px.green = '0;
         px.blue  = '0;
      end
      return px;
   endfunction

   task automatic flag_mismatch(input string what);
      if (mismatch_count < PRINT_CAP)
         $display("%0t mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic send_pixel(input logic [lsc_pkg::IDX_W-1:0] index, input logic lit,
                             input logic blank, input logic known,
                             input logic [lsc_pkg::COLOR_W-1:0] rgb);
      pixel_type want;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(lsc_pkg::REQ_TDATA_W - lsc_pkg::IDX_W){1'b0}}, index};
      req_tuser  <= {blank, lit};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (known) begin
         want.index = index;
         want.red   = rgb[23:16];
         want.green = rgb[15:8];
         want.blue  = rgb[7:0];
      end else
         want = shade_pixel(index, lit, blank);
      pixel_expect.push_back(want);
   endtask

   task automatic pace;
      if (!steady && $urandom_range(0, 99) < 30) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   task automatic send_random;
      logic [lsc_pkg::IDX_W-1:0] index;
      index = ($urandom_range(0, 99) < 85) ? lsc_pkg::IDX_W'($urandom_range(0, 290))
                                           : lsc_pkg::IDX_W'($urandom_range(0, 511));
      send_pixel(index, $urandom_range(0, 99) < 80, $urandom_range(0, 99) < 12, 1'b0, '0);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pixel_expect.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [lsc_pkg::CSR_IDX_W-1:0] which,
                            input logic [lsc_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (which)
         lsc_pkg::REG_MAIN_COLOR: main_cfg    = value;
         lsc_pkg::REG_BACK_COLOR: back_cfg    = value;
         lsc_pkg::REG_BRIGHTNESS: bright_cfg  = value[lsc_pkg::BRIGHT_W-1:0];
         lsc_pkg::REG_REDLINE:    redline_cfg = value[lsc_pkg::REDLINE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [lsc_pkg::COLOR_W-1:0] main_rgb,
                                input logic [lsc_pkg::COLOR_W-1:0] back_rgb,
                                input logic [lsc_pkg::BRIGHT_W-1:0] level,
                                input logic [lsc_pkg::REDLINE_W-1:0] red_count);
      drain();
      write_reg(lsc_pkg::REG_MAIN_COLOR, main_rgb);
      write_reg(lsc_pkg::REG_BACK_COLOR, back_rgb);
      write_reg(lsc_pkg::REG_BRIGHTNESS,
                {{(lsc_pkg::CSR_DATA_W - lsc_pkg::BRIGHT_W){1'b0}}, level});
      write_reg(lsc_pkg::REG_REDLINE,
                {{(lsc_pkg::CSR_DATA_W - lsc_pkg::REDLINE_W){1'b0}}, red_count});
   endtask

   task automatic run_random(input int count);
      repeat (count) begin
         pace();
         send_random();
      end
   endtask

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         rsp_tready  <= 1'b0;
         hold_left   <= LONG_HOLD - 1;
         hold_served <= hold_asked;
      end else
         rsp_tready <= steady || ($urandom_range(0, 99) >= 30);
   end

   always @(posedge clock) begin
      pixel_type seen;
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.index = rsp_tdata[8:0];
         seen.red   = rsp_tdata[16:9];
         seen.green = rsp_tdata[24:17];
         seen.blue  = rsp_tdata[32:25];
         if (pixel_expect.size() == 0)
            flag_mismatch($sformatf("unexpected pixel %0d", seen.index));
         else begin
            want = pixel_expect.pop_front();
            if (seen.index !== want.index)
               flag_mismatch($sformatf("pixel_index %0d, want %0d", seen.index, want.index));
            if (seen.red !== want.red)
               flag_mismatch($sformatf("pixel %0d red %0d, want %0d", want.index, seen.red,
                                       want.red));
            if (seen.green !== want.green)
               flag_mismatch($sformatf("pixel %0d green %0d, want %0d", want.index, seen.green,
                                       want.green));
            if (seen.blue !== want.blue)
               flag_mismatch($sformatf("pixel %0d blue %0d, want %0d", want.index, seen.blue,
                                       want.blue));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (led_rows[i]) begin
         pace();
         send_pixel(led_rows[i].index, led_rows[i].lit, led_rows[i].blank, led_rows[i].known,
                    led_rows[i].rgb);
      end
      run_random(100);

      // run without idling, then hold the receiver so the pipeline backs up
      load_settings(24'hFFFFFF, 24'hFFFFFF, 8'd255, 6'd49);
      steady = 1'b1;
      run_random(60);
      hold_asked = hold_asked + 1;
      run_random(40);
      steady = 1'b0;
      run_random(20);

      load_settings('0, lsc_pkg::COLOR_W'($urandom_range(0, 24'hFFFFFF)), 8'd0, 6'd0);
      run_random(120);

      load_settings(lsc_pkg::COLOR_W'($urandom_range(1, 24'hFFFFFF)),
                    lsc_pkg::COLOR_W'($urandom_range(0, 24'hFFFFFF)), 8'd100, 6'd63);
      run_random(60);
      drain();
      run_random(60);

      repeat (2) begin
         load_settings(lsc_pkg::COLOR_W'($urandom_range(0, 24'hFFFFFF)),
                       lsc_pkg::COLOR_W'($urandom_range(0, 24'hFFFFFF)),
                       lsc_pkg::BRIGHT_W'($urandom_range(0, 255)),
                       lsc_pkg::REDLINE_W'($urandom_range(0, 63)));
         run_random(120);
      end

      load_settings(lsc_pkg::COLOR_W'($urandom_range(1, 24'hFFFFFF)), '0, 8'd1, 6'd1);
      run_random(120);

      drain();
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: filelist.f
design/lsc_pkg.sv
design/lsc_channel_scale.sv
design/led_segment_color_scaler.sv
design/lsc_checker.sv
test/led_segment_color_scaler_tb.sv
